/* rtl/slb_pkg.sv */
// Shared types, constants and the square-root step for the soft-light blend unit.
// No dependencies; every other file imports this package.
package slb_pkg;

   localparam int unsigned STAGES = 5;

   localparam logic [7:0] PIX_HALF = 8'd128;
   localparam logic [7:0] PIX_FULL = 8'd255;

   // Exact floor(x/255): x*RECIP_WIDE >> 32 for x < 2^24, x*RECIP_NARROW >> 24 for x < 2^16
   localparam logic [24:0] RECIP_WIDE   = 25'd16843010;
   localparam logic [16:0] RECIP_NARROW = 17'd65794;

   typedef struct packed {
      logic [STAGES-1:0] load;
   } slb_stage_en_type;

   typedef struct packed {
      logic [9:0] rem;
      logic [7:0] root;
   } slb_sqrt_type;

   // One restoring square-root digit: bring down two radicand bits
   function automatic slb_sqrt_type sqrt_step(slb_sqrt_type cur, logic [1:0] pair);
      logic [11:0]  acc;
      logic [11:0]  trial;
      slb_sqrt_type nxt;
      acc   = {cur.rem, pair};
      trial = {2'b00, cur.root, 2'b01};
      if (acc >= trial) begin
         nxt.rem  = 10'(acc - trial);
         nxt.root = {cur.root[6:0], 1'b1};
      end else begin
         nxt.rem  = acc[9:0];
         nxt.root = {cur.root[6:0], 1'b0};
      end
      return nxt;
   endfunction

endpackage

/* rtl/slb_channel.sv */
// Five-stage datapath that blends one color channel in soft-light mode.
// Uses slb_pkg for constants, the stage-load struct and the square-root step.
module slb_channel import slb_pkg::*; (
   input  logic             clock,
   input  slb_stage_en_type stage_en,
   input  logic [7:0]       image,
   input  logic [7:0]       overlay,
   output logic [7:0]       blend
);

   // stage 1: decode overlay, linear term, square
   logic        low_in, mid_in, dec_in;
   logic [8:0]  twob;
   logic [7:0]  m_in, t1_mul, y_in, t1_in;
   logic [15:0] t1_prod, sq_in;

   logic        s1_low_ff, s1_dec_ff;
   logic [7:0]  s1_t1_ff, s1_y_ff;
   logic [15:0] s1_sq_ff;

   always_comb begin
      low_in  = overlay <= PIX_HALF;
      mid_in  = overlay == PIX_HALF;
      twob    = {overlay, 1'b0};
      m_in    = low_in ? 8'({1'b0, PIX_FULL} - twob) : 8'(twob - {1'b0, PIX_FULL});
      t1_mul  = low_in ? overlay : 8'(PIX_FULL - overlay);
      t1_prod = 16'(image) * 16'(t1_mul);
      t1_in   = t1_prod[14:7];
      sq_in   = low_in ? 16'(image) * 16'(image) : 16'(m_in) * 16'(m_in);
      y_in    = mid_in ? 8'd0 : (low_in ? m_in : image);
      dec_in  = mid_in && (image != 8'd0);
   end

   always_ff @(posedge clock) begin
      if (stage_en.load[0]) begin
         s1_low_ff <= low_in;
         s1_dec_ff <= dec_in;
         s1_t1_ff  <= t1_in;
         s1_y_ff   <= y_in;
         s1_sq_ff  <= sq_in;
      end
   end

   // stage 2: cubic numerator
   logic [23:0] n_in;
   logic        s2_low_ff, s2_dec_ff;
   logic [7:0]  s2_t1_ff;
   logic [23:0] s2_n_ff;

   assign n_in = 24'(s1_sq_ff) * 24'(s1_y_ff);

   always_ff @(posedge clock) begin
      if (stage_en.load[1]) begin
         s2_low_ff <= s1_low_ff;
         s2_dec_ff <= s1_dec_ff;
         s2_t1_ff  <= s1_t1_ff;
         s2_n_ff   <= n_in;
      end
   end

   // stage 3: first divide by 255
   logic [48:0] q1_prod;
   logic [15:0] q1_in;
   logic        s3_low_ff, s3_dec_ff;
   logic [7:0]  s3_t1_ff;
   logic [15:0] s3_q1_ff;

   assign q1_prod = 49'(s2_n_ff) * 49'(RECIP_WIDE);
   assign q1_in   = q1_prod[47:32];

   always_ff @(posedge clock) begin
      if (stage_en.load[2]) begin
         s3_low_ff <= s2_low_ff;
         s3_dec_ff <= s2_dec_ff;
         s3_t1_ff  <= s2_t1_ff;
         s3_q1_ff  <= q1_in;
      end
   end

   // stage 4: second divide by 255, upper square-root digits
   logic [32:0]  q2_prod;
   logic [7:0]   q2_in;
   slb_sqrt_type sq_hi_in;
   logic         s4_low_ff, s4_dec_ff;
   logic [7:0]   s4_t1_ff, s4_q2_ff, s4_lo_bits_ff;
   slb_sqrt_type s4_sqrt_ff;

   assign q2_prod = 33'(s3_q1_ff) * 33'(RECIP_NARROW);
   assign q2_in   = q2_prod[31:24];

   always_comb begin
      slb_sqrt_type acc;
      acc = '0;
      for (int i = 3; i >= 0; i--) begin
         acc = sqrt_step(acc, s3_q1_ff[8 + 2*i +: 2]);
      end
      sq_hi_in = acc;
   end

   always_ff @(posedge clock) begin
      if (stage_en.load[3]) begin
         s4_low_ff     <= s3_low_ff;
         s4_dec_ff     <= s3_dec_ff;
         s4_t1_ff      <= s3_t1_ff;
         s4_q2_ff      <= q2_in;
         s4_lo_bits_ff <= s3_q1_ff[7:0];
         s4_sqrt_ff    <= sq_hi_in;
      end
   end

   // stage 5: lower square-root digits, sum and saturate
   logic [7:0] root;
   logic [7:0] t2;
   logic [8:0] sum;
   logic [7:0] blend_in;
   logic [7:0] blend_ff;

   always_comb begin
      slb_sqrt_type acc;
      acc = s4_sqrt_ff;
      for (int i = 3; i >= 0; i--) begin
         acc = sqrt_step(acc, s4_lo_bits_ff[2*i +: 2]);
      end
      root = acc.root;
   end

   always_comb begin
      t2       = s4_low_ff ? s4_q2_ff : root;
      sum      = 9'(s4_t1_ff) + 9'(t2) - 9'(s4_dec_ff);
      blend_in = sum[8] ? PIX_FULL : sum[7:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en.load[4]) begin
         blend_ff <= blend_in;
      end
   end

   assign blend = blend_ff;

endmodule

/* rtl/soft_light_blend_unit.sv */
// Top level of the soft-light blend unit: stage valid bits, stall chain, three channels.
// Depends on slb_pkg and slb_channel.
//
//   port group   dir   payload                          handshake
//   req_         in    image_ch0..2, overlay_ch0..2     req_valid / req_stall
//   rsp_         out   blend_ch0..2                     rsp_valid / rsp_stall
//
// One pixel per clock while rsp_stall is low; the multiply, double divide-by-255
// and 8-digit square-root chain is spread over five stages.
// Reset clears the stage valid bits only.
// A stall at the output backs up stage by stage; empty stages still load, so
// req_stall rises only once every stage holds a request.
module soft_light_blend_unit import slb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_image_ch0,
   input  logic [7:0] req_image_ch1,
   input  logic [7:0] req_image_ch2,
   input  logic [7:0] req_overlay_ch0,
   input  logic [7:0] req_overlay_ch1,
   input  logic [7:0] req_overlay_ch2,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_blend_ch0,
   output logic [7:0] rsp_blend_ch1,
   output logic [7:0] rsp_blend_ch2
);

   logic [STAGES-1:0] valid_ff, valid_in;
   logic [STAGES:0]   ready;
   slb_stage_en_type  stage_en;

   always_comb begin
      ready[STAGES] = !rsp_stall;
      for (int k = STAGES - 1; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
   end

   always_comb begin
      stage_en.load = ready[STAGES-1:0];
      if (ready[0]) begin
         valid_in[0] = req_valid;
      end else begin
         valid_in[0] = valid_ff[0];
      end
      for (int k = 1; k < STAGES; k++) begin
         if (ready[k]) begin
            valid_in[k] = valid_ff[k-1];
         end else begin
            valid_in[k] = valid_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !ready[0];
   assign rsp_valid = valid_ff[STAGES-1];

   slb_channel u_ch0 (
      .clock    (clock),
      .stage_en (stage_en),
      .image    (req_image_ch0),
      .overlay  (req_overlay_ch0),
      .blend    (rsp_blend_ch0)
   );

   slb_channel u_ch1 (
      .clock    (clock),
      .stage_en (stage_en),
      .image    (req_image_ch1),
      .overlay  (req_overlay_ch1),
      .blend    (rsp_blend_ch1)
   );

   slb_channel u_ch2 (
      .clock    (clock),
      .stage_en (stage_en),
      .image    (req_image_ch2),
      .overlay  (req_overlay_ch2),
      .blend    (rsp_blend_ch2)
   );

`ifndef NO_ASSERTIONS
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&valid_ff))
      else $error("input stalled while a stage is empty");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> valid_ff[0])
      else $error("accepted request did not enter the first stage");

   a_fill_rate: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) <= $past($countones(valid_ff)) + 1)
      else $error("pipeline occupancy grew by more than one request");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !valid_ff[STAGES-2]) |=> !rsp_valid)
      else $error("result repeated after delivery");
`endif

endmodule

/* verif/soft_light_blend_unit_tb.sv */
// Self-checking testbench for soft_light_blend_unit: a directed table, then random pixels
// with random idling on both channels, each result checked against the table or a behavioral blend model.
// Depends on slb_pkg and the soft_light_blend_unit RTL.
`timescale 1ns / 100ps

module soft_light_blend_unit_tb import slb_pkg::*; ();

   localparam int RANDOM_PIXELS = 1350;
   localparam int CALM_FIRST    = 400;
   localparam int CALM_LAST     = 700;
   localparam int IDLE_PERCENT  = 32;
   localparam int REPORT_LIMIT  = 10;

   typedef struct packed {
      logic [23:0] image;
      logic [23:0] overlay;
      logic        known;
      logic [23:0] blend;
   } blend_case_type;

   // Channel 0 sits in the low byte of each 24-bit word.
   localparam int CASE_COUNT = 18;
   localparam blend_case_type BLEND_CASES [CASE_COUNT] = '{
      {24'h000000, 24'h000000, 1'b1, 24'h000000},
      {24'hFFFFFF, 24'hFFFFFF, 1'b1, 24'hFFFFFF},
      {24'hFFFFFF, 24'h000000, 1'b1, 24'hFFFFFF},
      {24'h000000, 24'hFFFFFF, 1'b1, 24'h000000},
      {24'h0001FF, 24'h808080, 1'b1, 24'h0000FE},
      {24'hC84080, 24'h808080, 1'b1, 24'hC73F7F},
      {24'hFF00FF, 24'h80FF80, 1'b1, 24'hFE00FE},
      {24'hFFFFFF, 24'h01817F, 1'b0, 24'h000000},
      {24'h030201, 24'hFEFEFE, 1'b0, 24'h000000},
      {24'h55AA55, 24'hAA55AA, 1'b0, 24'h000000},
      {24'hAA55AA, 24'h55AA55, 1'b0, 24'h000000},
      {24'h7F807F, 24'h7F7F81, 1'b0, 24'h000000},
      {24'h010101, 24'h000000, 1'b0, 24'h000000},
      {24'hFEFEFE, 24'h010101, 1'b0, 24'h000000},
      {24'h808080, 24'h408040, 1'b0, 24'h000000},
      {24'h112233, 24'hC0C0C0, 1'b0, 24'h000000},
      {24'hF0E0D0, 24'h102030, 1'b0, 24'h000000},
      {24'h0F1E2D, 24'hFF00FF, 1'b0, 24'h000000}
   };

   logic       clock           = 1'b0;
   logic       reset           = 1'b1;
   logic       req_valid       = 1'b0;
   logic       req_stall;
   logic [7:0] req_image_ch0   = 8'd0;
   logic [7:0] req_image_ch1   = 8'd0;
   logic [7:0] req_image_ch2   = 8'd0;
   logic [7:0] req_overlay_ch0 = 8'd0;
   logic [7:0] req_overlay_ch1 = 8'd0;
   logic [7:0] req_overlay_ch2 = 8'd0;
   logic       rsp_valid;
   logic       rsp_stall       = 1'b1;
   logic [7:0] rsp_blend_ch0;
   logic [7:0] rsp_blend_ch1;
   logic [7:0] rsp_blend_ch2;

   logic [23:0] blend_due [$];
   int          mismatches = 0;
   bit          calm       = 1'b0;

   soft_light_blend_unit u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_image_ch0   (req_image_ch0),
      .req_image_ch1   (req_image_ch1),
      .req_image_ch2   (req_image_ch2),
      .req_overlay_ch0 (req_overlay_ch0),
      .req_overlay_ch1 (req_overlay_ch1),
      .req_overlay_ch2 (req_overlay_ch2),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_blend_ch0   (rsp_blend_ch0),
      .rsp_blend_ch1   (rsp_blend_ch1),
      .rsp_blend_ch2   (rsp_blend_ch2)
   );

   always #6 clock = ~clock;

   function automatic int unsigned root_floor(input int unsigned x);
      int unsigned r;
      int unsigned t;
      r = 0;
      for (int i = 15; i >= 0; i--) begin
         t = r | (32'd1 << i);
         if (t * t <= x) begin
            r = t;
         end
      end
      return r;
   endfunction

   function automatic logic [7:0] soft_light_channel(input logic [7:0] a, input logic [7:0] b);
      int          sa;
      int          sb;
      int          prod;
      int          c;
      int unsigned d;
      int unsigned q;
      sa = a;
      sb = b;
      if (sb <= 128) begin
         prod = sa * sa * (255 - 2 * sb);
         c = (sa * sb) / 128 + ((prod >= 0) ? prod / 65025 : -((-prod + 65024) / 65025));
      end else begin
         d = 2 * sb - 255;
         q = (int'(a) * d * d) / 255;
         c = (sa * (255 - sb)) / 128 + int'(root_floor(q));
      end
      if (c < 0) begin
         c = 0;
      end
      if (c > 255) begin
         c = 255;
      end
      return c[7:0];
   endfunction

   function automatic logic [23:0] soft_light_pixel(input logic [23:0] image,
                                                    input logic [23:0] overlay);
      logic [23:0] blend;
      for (int ch = 0; ch < 3; ch++) begin
         blend[ch*8 +: 8] = soft_light_channel(image[ch*8 +: 8], overlay[ch*8 +: 8]);
      end
      return blend;
   endfunction

   function automatic logic [7:0] random_overlay();
      case ($urandom_range(0, 9))
         0: return 8'd128;
         1: return 8'd0;
         2: return 8'd255;
         3: return 8'($urandom_range(127, 129));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [7:0] random_image();
      case ($urandom_range(0, 9))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic push_pixel(input logic [23:0] image, input logic [23:0] overlay,
                             input logic [23:0] blend);
      while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_image_ch0   <= image[7:0];
      req_image_ch1   <= image[15:8];
      req_image_ch2   <= image[23:16];
      req_overlay_ch0 <= overlay[7:0];
      req_overlay_ch1 <= overlay[15:8];
      req_overlay_ch2 <= overlay[23:16];
      do @(posedge clock); while (req_stall);
      blend_due.push_back(blend);
   endtask

   always @(posedge clock) begin
      logic [23:0] want;
      logic [23:0] got;
      rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_blend_ch2, rsp_blend_ch1, rsp_blend_ch0};
         if (blend_due.size() == 0) begin
            if (mismatches < REPORT_LIMIT) begin
               $display("unexpected result blend=%h at %0t", got, $realtime);
            end
            mismatches++;
         end else begin
            want = blend_due.pop_front();
            for (int ch = 0; ch < 3; ch++) begin
               if (got[ch*8 +: 8] !== want[ch*8 +: 8]) begin
                  if (mismatches < REPORT_LIMIT) begin
                     $display("blend_ch%0d mismatch: expected %0d, got %0d at %0t",
                              ch, want[ch*8 +: 8], got[ch*8 +: 8], $realtime);
                  end
                  mismatches++;
               end
            end
         end
      end
   end

   initial begin
      logic [23:0] image;
      logic [23:0] overlay;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < CASE_COUNT; i++) begin
         push_pixel(BLEND_CASES[i].image, BLEND_CASES[i].overlay,
                    BLEND_CASES[i].known ? BLEND_CASES[i].blend :
                    soft_light_pixel(BLEND_CASES[i].image, BLEND_CASES[i].overlay));
      end
      for (int i = 0; i < RANDOM_PIXELS; i++) begin
         calm = (i >= CALM_FIRST) && (i < CALM_LAST);
         image   = {random_image(), random_image(), random_image()};
         overlay = {random_overlay(), random_overlay(), random_overlay()};
         push_pixel(image, overlay, soft_light_pixel(image, overlay));
      end
      calm = 1'b0;
      req_valid <= 1'b0;
      while (blend_due.size() != 0) @(posedge clock);
      repeat (4 * STAGES) @(posedge clock);
      if (mismatches == 0 && blend_due.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("Some tests failed");
      $finish;
   end

endmodule

/* filelist.f */
rtl/slb_pkg.sv
rtl/slb_channel.sv
rtl/soft_light_blend_unit.sv
verif/soft_light_blend_unit_tb.sv
